// File: src/occupancy_grid_disc_inflation_assert.svh
// ----------------------------------------------------------------------------
// occupancy_grid_disc_inflation_assert.svh
// assertion macros for the port level checker of the grid inflation block
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_DISC_INFLATION_ASSERT_SVH
`define OCCUPANCY_GRID_DISC_INFLATION_ASSERT_SVH

// clocked on aclk, muted while aresetn is low
`define OGDI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked on aclk, live through reset as well
`define OGDI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: src/ogdi_pkg.sv
// ----------------------------------------------------------------------------
// ogdi_pkg
// shared widths, codes and constants of the occupancy grid inflation block
// ----------------------------------------------------------------------------
package ogdi_pkg;

    localparam int COORD_W   = 8;
    localparam int VALUE_W   = 8;
    localparam int DIM_W     = 9;
    localparam int RAD_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 8;

    // operation codes carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_CELLS = 2'd2;

    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 9'd256;
    localparam logic [RAD_W-1:0] RADIUS_RST      = 4'd3;

    localparam logic [VALUE_W-1:0] OCCUPIED = 8'd100;

endpackage

// File: src/ogdi_ram.sv
// ----------------------------------------------------------------------------
// ogdi_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ogdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/occupancy_grid_disc_inflation.sv
// ----------------------------------------------------------------------------
// occupancy_grid_disc_inflation
// obstacle inflation of an occupancy grid by a disc of cells
//
// Input words on s_*: tuser is the operation (write or read), tdata carries
// col, row and cell_value. A write stores the original cell and answers in
// the cycle after acceptance. A read scans the (2R+1)^2 square around the
// cell, R being the radius in use, one position per cycle, and reads the
// grid store through the single read port at each position inside the grid
// and the disc; it then drains and answers once the output is free. Words
// outside the grid answer in the cycle after acceptance with valid_res 0.
// Result words on m_*: tdata is result_value, tuser is valid_res. The result
// sits in an output register; a stalled receiver holds it there and the
// block takes a new word once that register is free or being emptied. One
// item is in progress at a time. Reset (aresetn low, synchronous) restores
// the configuration defaults and empties the output; the grid store is not
// cleared and must be written before it is read. Configuration must be
// written through cfg_* only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module occupancy_grid_disc_inflation #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [ogdi_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ogdi_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ogdi_pkg::S_DATA_W-1:0]    s_tdata,   // col, row, cell_value
    input  logic                             s_tuser,   // op
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ogdi_pkg::M_DATA_W-1:0]    m_tdata,   // result_value
    output logic                             m_tuser    // valid_res
);

    import ogdi_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int OFF_W = 6;
    localparam int POS_W = 10;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DIM_W-1:0]   grid_width_reg, grid_height_reg;
    logic [RAD_W-1:0]   radius_reg;

    logic [COORD_W-1:0] col_reg, row_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic signed [OFF_W-1:0] dx_reg, dy_reg;
    logic               rd_pend_reg, rd_centre_reg;
    logic               hit_reg;
    logic [VALUE_W-1:0] centre_reg;

    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_data_reg;
    logic               m_user_reg;

    logic [DIM_W-1:0]   eff_w, eff_h;
    logic [RAD_W-1:0]   eff_rad;
    logic [COORD_W-1:0] in_col, in_row;
    logic [VALUE_W-1:0] in_value;
    logic               in_accept, in_inside, out_free;

    logic signed [POS_W-1:0] nx, ny;
    logic [RAD_W-1:0]   adx, ady;
    logic [2*RAD_W:0]   dist2;
    logic [2*RAD_W-1:0] lim;
    logic               nb_ok, last_dx, last_dy;
    logic signed [OFF_W-1:0] rad_s;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_q;

    // clipped register values
    always_comb begin
        eff_w   = (32'(grid_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width_reg;
        eff_h   = (32'(grid_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height_reg;
        eff_rad = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
    end

    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_value  = s_tdata[23:16];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign in_inside = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_h);

    // neighbour under test in this scan step
    always_comb begin
        nx    = $signed({2'b00, col_reg}) + POS_W'(dx_reg);
        ny    = $signed({2'b00, row_reg}) + POS_W'(dy_reg);
        adx   = dx_reg[OFF_W-1] ? RAD_W'(-dx_reg) : dx_reg[RAD_W-1:0];
        ady   = dy_reg[OFF_W-1] ? RAD_W'(-dy_reg) : dy_reg[RAD_W-1:0];
        dist2 = (2*RAD_W+1)'(adx) * (2*RAD_W+1)'(adx)
              + (2*RAD_W+1)'(ady) * (2*RAD_W+1)'(ady);
        lim   = (2*RAD_W)'(rad_reg) * (2*RAD_W)'(rad_reg);
        nb_ok = (nx >= 0) && (nx < $signed({1'b0, eff_w}))
             && (ny >= 0) && (ny < $signed({1'b0, eff_h}))
             && (dist2 <= (2*RAD_W+1)'(lim));
        rad_s   = $signed({{(OFF_W-RAD_W){1'b0}}, rad_reg});
        last_dx = (dx_reg == rad_s);
        last_dy = (dy_reg == rad_s);
    end

    assign ram_we    = in_accept && in_inside && (s_tuser == OP_WRITE);
    assign ram_waddr = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
    assign ram_re    = (state_reg == ST_SCAN) && nb_ok;
    assign ram_raddr = AW'(ny[COORD_W-1:0]) * AW'(MAX_WIDTH) + AW'(nx[COORD_W-1:0]);

    ogdi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_inside && (s_tuser == OP_READ)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_dx && last_dy) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            radius_reg      <= RADIUS_RST;
            m_valid_reg     <= 1'b0;
            rd_pend_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= ram_re;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_GRID_WIDTH:   grid_width_reg  <= cfg_data;
                    CFG_GRID_HEIGHT:  grid_height_reg <= cfg_data;
                    CFG_RADIUS_CELLS: radius_reg      <= cfg_data[RAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_accept && !(in_inside && (s_tuser == OP_READ))) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath and result payload
    always_ff @(posedge aclk) begin
        rd_centre_reg <= ram_re && (dx_reg == '0) && (dy_reg == '0);
        if (in_accept) begin
            col_reg <= in_col;
            row_reg <= in_row;
            rad_reg <= eff_rad;
            dx_reg  <= -$signed({{(OFF_W-RAD_W){1'b0}}, eff_rad});
            dy_reg  <= -$signed({{(OFF_W-RAD_W){1'b0}}, eff_rad});
            hit_reg <= 1'b0;
            if (!(in_inside && (s_tuser == OP_READ))) begin
                m_data_reg <= '0;
                m_user_reg <= in_inside;
            end
        end else if (state_reg == ST_SCAN) begin
            if (last_dx) begin
                dx_reg <= -rad_s;
                dy_reg <= dy_reg + OFF_W'(1);
            end else begin
                dx_reg <= dx_reg + OFF_W'(1);
            end
        end
        if (rd_pend_reg && (ram_q == OCCUPIED)) begin
            hit_reg <= 1'b1;
        end
        if (rd_pend_reg && rd_centre_reg) begin
            centre_reg <= ram_q;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= hit_reg ? OCCUPIED : centre_reg;
            m_user_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: src/ogdi_check.sv
// ----------------------------------------------------------------------------
// ogdi_check
// port level checks of the grid inflation block, bound to the top level
// ----------------------------------------------------------------------------
`include "occupancy_grid_disc_inflation_assert.svh"

module ogdi_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ogdi_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    import ogdi_pkg::*;

    // output empties on reset
    `OGDI_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid,
        "result word present after reset")

    // stalled result word holds
    `OGDI_ASSERT(a_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled result word changed")

    // a new word is taken only when the output register has room
    `OGDI_ASSERT(a_room, s_tready |-> !m_tvalid || m_tready,
        "input taken with output register full")

    // write words answer in the next cycle with a zero value
    `OGDI_ASSERT(a_wr_ans,
        s_tvalid && s_tready && (s_tuser == OP_WRITE) |=> m_tvalid && (m_tdata == '0),
        "write word not answered with zero")

    // cells outside the grid always report zero
    `OGDI_ASSERT(a_outside, m_tvalid && !m_tuser |-> m_tdata == '0,
        "outside cell with non-zero value")

endmodule

bind occupancy_grid_disc_inflation ogdi_check u_ogdi_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/occupancy_grid_disc_inflation_test.sv
// ----------------------------------------------------------------------------
// occupancy_grid_disc_inflation_test
// self-checking bench for the disc inflation of an occupancy grid
//
// Cells are loaded and read through the s_* stream, and every result word on
// m_* is checked against a predictor that keeps its own copy of the grid and
// the configuration. A directed part covers the disc boundary, the grid edges,
// a zero radius and the zero and oversized grid settings. After it come random
// phases over many grid shapes and radii. Before a cell is read, the bench
// writes any cell of its disc that was never written. Both sides idle at
// random, and the sender drains the block at least once per phase.
// ----------------------------------------------------------------------------
module occupancy_grid_disc_inflation_test;

    import ogdi_pkg::*;

    localparam int GRID_SPAN      = 256;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 1100;   // beyond the slowest read, radius 15
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FILL_LIMIT     = 150;
    localparam int PHASE_ITEMS    = 36;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               valid;
    } cell_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // col, row, cell_value
    logic                  s_tuser   = 1'b0; // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // result_value
    logic                  m_tuser;          // valid_res

    // predictor state
    logic [VALUE_W-1:0] grid_mirror [0:GRID_SPAN*GRID_SPAN-1];
    bit                 cell_written [0:GRID_SPAN*GRID_SPAN-1];
    logic [DIM_W-1:0]   width_reg  = GRID_WIDTH_RST;
    logic [DIM_W-1:0]   height_reg = GRID_HEIGHT_RST;
    logic [RAD_W-1:0]   radius_reg = RADIUS_RST;

    cell_result_t inflated_q [$];
    cell_result_t oldest_expected;

    int error_count = 0;
    int idle_cycles = 0;
    int occ_pct     = 10;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    occupancy_grid_disc_inflation uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic int eff_dim(input logic [DIM_W-1:0] raw);
        return (raw > GRID_SPAN) ? GRID_SPAN : int'(raw);
    endfunction

    function automatic int draw_gap(input bit steady);
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < occ_pct)
            return OCCUPIED;
        else if (roll < 55)
            return 8'h00;
        else if (roll < 75)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // inflated value of one word; a write inside the grid updates the mirror
    function automatic cell_result_t predict_word(input logic op,
                                                  input logic [7:0] col,
                                                  input logic [7:0] row,
                                                  input logic [VALUE_W-1:0] val);
        cell_result_t res;
        int we, he, rad, nx, ny;
        bit hit;
        we  = eff_dim(width_reg);
        he  = eff_dim(height_reg);
        rad = int'(radius_reg);
        hit = 1'b0;
        res.value = '0;
        res.valid = (int'(col) < we) && (int'(row) < he);
        if (res.valid) begin
            if (op == OP_WRITE) begin
                grid_mirror[{row, col}]  = val;
                cell_written[{row, col}] = 1'b1;
            end else begin
                for (int dy = -rad; dy <= rad; dy++) begin
                    ny = int'(row) + dy;
                    for (int dx = -rad; dx <= rad; dx++) begin
                        nx = int'(col) + dx;
                        if (ny >= 0 && ny < he && nx >= 0 && nx < we &&
                            dx * dx + dy * dy <= rad * rad &&
                            grid_mirror[ny * GRID_SPAN + nx] == OCCUPIED)
                            hit = 1'b1;
                    end
                end
                res.value = hit ? OCCUPIED : grid_mirror[{row, col}];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < REPORT_LIMIT)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (inflated_q.size() == 0) begin
                report_mismatch("unexpected result word", int'(m_tdata), 0);
            end else begin
                oldest_expected = inflated_q.pop_front();
                if (m_tdata !== oldest_expected.value)
                    report_mismatch("result_value", int'(m_tdata),
                                    int'(oldest_expected.value));
                if (m_tuser !== oldest_expected.valid)
                    report_mismatch("valid_res", int'(m_tuser),
                                    int'(oldest_expected.valid));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("occupancy_grid_disc_inflation_test: done, errors");
                $finish;
            end
        end
    end

    // receiver: random stall before each result word
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = draw_gap(rx_steady);
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_word(input logic op, input logic [7:0] col,
                             input logic [7:0] row, input logic [VALUE_W-1:0] val);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        inflated_q.insert(inflated_q.size(), predict_word(op, col, row, val));
    endtask

    task automatic wait_until_drained();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (inflated_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_GRID_WIDTH:   width_reg  = data;
            CFG_GRID_HEIGHT:  height_reg = data;
            CFG_RADIUS_CELLS: radius_reg = data[RAD_W-1:0];
            default: ;
        endcase
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [RAD_W-1:0] rad);
        wait_until_drained();
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_RADIUS_CELLS, {{(CFG_DATA_W-RAD_W){1'b0}}, rad});
    endtask

    // write whatever the disc still lacks, then read the cell
    task automatic fill_and_read(input logic [7:0] col, input logic [7:0] row);
        int we, he, rad, nx, ny;
        we  = eff_dim(width_reg);
        he  = eff_dim(height_reg);
        rad = int'(radius_reg);
        for (int dy = -rad; dy <= rad; dy++) begin
            ny = int'(row) + dy;
            for (int dx = -rad; dx <= rad; dx++) begin
                nx = int'(col) + dx;
                if (ny >= 0 && ny < he && nx >= 0 && nx < we &&
                    dx * dx + dy * dy <= rad * rad &&
                    !cell_written[ny * GRID_SPAN + nx])
                    send_word(OP_WRITE, nx[7:0], ny[7:0], pick_value());
            end
        end
        send_word(OP_READ, col, row, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_coord(input int base, input int span, input int dim);
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(dim - 1);
        return 8'(base + $urandom_range(0, span - 1));
    endfunction

    task automatic run_phase(input int w_raw, input int h_raw, input int rad, input int n_items);
        int we, he, cw, rh, c0, r0, pause_at, roll;
        logic [7:0] col, row;
        set_geometry(w_raw[DIM_W-1:0], h_raw[DIM_W-1:0], rad[RAD_W-1:0]);
        we = eff_dim(width_reg);
        he = eff_dim(height_reg);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        occ_pct   = $urandom_range(1, 15);
        // most traffic stays in a window so that reads need few fill writes
        cw = (we < 24) ? we : 24;
        rh = (he < 24) ? he : 24;
        c0 = (we > cw) ? $urandom_range(0, we - cw) : 0;
        r0 = (he > rh) ? $urandom_range(0, he - rh) : 0;
        if (we * he > 0 && we * he <= FILL_LIMIT) begin
            for (int r = 0; r < he; r++)
                for (int c = 0; c < we; c++)
                    send_word(OP_WRITE, c[7:0], r[7:0], pick_value());
        end
        pause_at = $urandom_range(0, n_items - 1);
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at)
                wait_until_drained();
            roll = $urandom_range(0, 99);
            if (we == 0 || he == 0) begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (roll < 10 && (we < GRID_SPAN || he < GRID_SPAN)) begin
                if (we < GRID_SPAN && ($urandom_range(0, 1) == 0 || he == GRID_SPAN)) begin
                    col = 8'($urandom_range(we, 255));
                    row = 8'($urandom_range(0, 255));
                end else begin
                    col = 8'($urandom_range(0, 255));
                    row = 8'($urandom_range(he, 255));
                end
                send_word(1'($urandom_range(0, 1)), col, row, 8'($urandom_range(0, 255)));
            end else begin
                col = pick_coord(c0, cw, we);
                row = pick_coord(r0, rh, he);
                if (roll < 55)
                    send_word(OP_WRITE, col, row, pick_value());
                else
                    fill_and_read(col, row);
            end
        end
    endtask

    // default grid: a cell just outside the disc, then one on its rim
    task automatic test_disc_boundary();
        logic [VALUE_W-1:0] v;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                v = 8'h00;
                if (r == 0 && c == 0)
                    v = 8'h80;
                else if (r == 0 && c == 1)
                    v = 8'h7f;
                else if (r == 0 && c == 2)
                    v = 8'hff;
                else if (r == 1 && c == 3)
                    v = OCCUPIED;
                send_word(OP_WRITE, c[7:0], r[7:0], v);
            end
        end
        fill_and_read(8'd0, 8'd0);
        send_word(OP_WRITE, 8'd3, 8'd0, OCCUPIED);
        fill_and_read(8'd0, 8'd0);
    endtask

    task automatic test_grid_limits();
        // stored cells keep their place when the grid shrinks
        set_geometry(9'd4, 9'd4, 4'd3);
        fill_and_read(8'd1, 8'd1);
        send_word(OP_WRITE, 8'd4, 8'd2, 8'd55);
        send_word(OP_READ, 8'd2, 8'd4, 8'h00);
        send_word(OP_READ, 8'd255, 8'd255, 8'hff);
        set_geometry(9'd4, 9'd4, 4'd0);
        fill_and_read(8'd2, 8'd1);
        // zero width: everything lies outside, the write is dropped
        set_geometry(9'd0, 9'd4, 4'd1);
        send_word(OP_READ, 8'd0, 8'd0, 8'h00);
        send_word(OP_WRITE, 8'd0, 8'd0, OCCUPIED);
        set_geometry(9'd4, 9'd4, 4'd1);
        fill_and_read(8'd0, 8'd0);
        // oversized width saturates to the full span
        set_geometry(9'd400, 9'd4, 4'd1);
        fill_and_read(8'd255, 8'd3);
    endtask

    task automatic test_geometry_sweep();
        run_phase(8, 8, 1, PHASE_ITEMS);
        run_phase(5, 3, 0, PHASE_ITEMS);
        run_phase(1, 1, 2, PHASE_ITEMS);
        run_phase(16, 9, 4, PHASE_ITEMS);
        run_phase(256, 256, 2, PHASE_ITEMS);
        run_phase(300, 511, 1, PHASE_ITEMS);
        run_phase(0, 20, 2, PHASE_ITEMS);
        run_phase(1, 256, 3, PHASE_ITEMS);
        run_phase(256, 1, 5, PHASE_ITEMS);
        run_phase(12, 12, 15, PHASE_ITEMS);
        run_phase(10, 7, 7, PHASE_ITEMS);
        run_phase(2, 9, 3, PHASE_ITEMS);
    endtask

    task automatic test_random_geometry();
        for (int p = 0; p < 5; p++)
            run_phase($urandom_range(1, 14), $urandom_range(1, 14),
                      $urandom_range(0, 6), PHASE_ITEMS);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        test_disc_boundary();
        test_grid_limits();
        test_geometry_sweep();
        test_random_geometry();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (inflated_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("occupancy_grid_disc_inflation_test: done, clean");
        else
            $display("occupancy_grid_disc_inflation_test: done, errors");
        $finish;
    end

endmodule

// File: occupancy_grid_disc_inflation.f
+incdir+src
src/ogdi_pkg.sv
src/ogdi_ram.sv
src/occupancy_grid_disc_inflation.sv
src/ogdi_check.sv
tb/sv/occupancy_grid_disc_inflation_test.sv
